// ===== sv/qtn_pkg.sv =====
// qtn_pkg: shared types and character codes for the query text normalizer.
// No dependencies; imported by qtn_step, qtn_obuf and query_text_normalizer.
package qtn_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // per-query parser state
    typedef struct packed {
        logic [7:0] prev_char;
        logic       in_phrase;
        logic [7:0] held_char;
        logic       held_valid;
        logic [7:0] before_held;
        logic       any_committed;
        logic       aborted;
    } qtn_state_t;

    localparam qtn_state_t STATE_CLEAR = '{
        prev_char:     CH_AMP,
        in_phrase:     1'b0,
        held_char:     CH_NUL,
        held_valid:    1'b0,
        before_held:   CH_NUL,
        any_committed: 1'b0,
        aborted:       1'b0
    };

    // one result word
    typedef struct packed {
        logic       invalid;
        logic       last;
        logic       valid_char;
        logic [7:0] ch;
    } qtn_res_t;

    // result buffer status toward the input stage
    typedef struct packed {
        logic room;
        logic busy;
    } qtn_obuf_stat_t;

endpackage

// ===== sv/qtn_step.sv =====
// qtn_step: combinational processing of one input byte against the parser state.
// Produces the next state and up to three result words. Depends on qtn_pkg.
module qtn_step (
    input  qtn_pkg::qtn_state_t       st_i,
    input  logic [7:0]                ch_i,
    input  logic                      last_i,
    input  logic                      mode_i,
    output qtn_pkg::qtn_state_t       st_o,
    output qtn_pkg::qtn_res_t [2:0]   ent_o,
    output logic [1:0]                cnt_o
);
    import qtn_pkg::*;

    typedef struct packed {
        qtn_state_t      st;
        logic [1:0][7:0] ech;
        logic [1:0]      n;
    } step_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h0C || c == 8'h0A || c == 8'h0D ||
               c == 8'h09 || c == 8'h0B;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_mark(input logic [7:0] c, input logic m);
        logic r;
        r = is_space(c);
        if (c == CH_PIPE || c == CH_AMP || c == CH_DOLLAR || c == CH_QUOTE ||
            c == CH_TILDE) begin
            r = 1'b1;
        end
        if (c == CH_LPAREN || c == CH_RPAREN) begin
            r = m;
        end
        return r;
    endfunction

    function automatic step_t emit_f(input step_t s, input logic [7:0] c);
        step_t r;
        r = s;
        if (r.n != 2'd2) begin
            r.ech[r.n[0]] = c;
            r.n = r.n + 2'd1;
        end
        return r;
    endfunction

    function automatic step_t commit_f(input step_t s);
        step_t r;
        logic  bh_op;
        r = s;
        bh_op = r.st.before_held == CH_LPAREN || r.st.before_held == CH_PIPE ||
                r.st.before_held == CH_AMP || r.st.before_held == CH_TILDE;
        if (r.st.held_char == CH_DOLLAR) begin
            if (r.st.any_committed && !bh_op) begin
                r = emit_f(r, CH_AMP);
            end
        end else begin
            r = emit_f(r, r.st.held_char);
        end
        r.st.before_held = r.st.held_char;
        r.st.any_committed = 1'b1;
        return r;
    endfunction

    function automatic step_t push_f(input step_t s, input logic [7:0] c);
        step_t r;
        r = s;
        if (r.st.held_valid) begin
            r = commit_f(r);
        end
        r.st.held_char = c;
        r.st.held_valid = 1'b1;
        return r;
    endfunction

    function automatic step_t replace_f(input step_t s, input logic [7:0] c);
        step_t r;
        r = s;
        if (r.st.held_valid) begin
            r.st.held_char = c;
        end else begin
            r = push_f(r, c);
        end
        return r;
    endfunction

    step_t      s;
    logic [7:0] c;
    logic [7:0] joiner;
    logic       alpha;
    logic       sym;
    logic       ws;
    logic       done;
    qtn_res_t   fin;

    always_comb begin
        s.st   = st_i;
        s.ech  = '0;
        s.n    = 2'd0;
        c      = ch_i;
        if (ch_i >= 8'h41 && ch_i <= 8'h5A) begin
            c = ch_i + 8'h20;
        end
        joiner = mode_i ? CH_AMP : CH_SPACE;
        alpha  = is_letter(c);
        sym    = is_mark(c, mode_i);
        ws     = is_space(c);
        done   = 1'b0;

        if (!st_i.aborted && (alpha || sym)) begin
            if (c == CH_QUOTE) begin
                s.st.in_phrase = ~s.st.in_phrase;
                if (is_space(s.st.prev_char)) begin
                    if (s.st.in_phrase && mode_i) begin
                        s = replace_f(s, CH_AMP);
                    end
                    if (!s.st.in_phrase) begin
                        s = replace_f(s, CH_QUOTE);
                        s.st.prev_char = CH_QUOTE;
                        done = 1'b1;
                    end
                end
                if (!done && s.st.prev_char == CH_QUOTE) begin
                    if (!s.st.in_phrase) begin
                        s.st.aborted = 1'b1;
                        done = 1'b1;
                    end else begin
                        s = push_f(s, joiner);
                    end
                end
                if (!done) begin
                    s = push_f(s, CH_QUOTE);
                    s.st.prev_char = CH_QUOTE;
                end
            end else if (!(s.st.in_phrase && sym && !ws)) begin
                if (c == CH_LPAREN) begin
                    if (is_letter(s.st.prev_char) || s.st.prev_char == CH_RPAREN ||
                        s.st.prev_char == CH_QUOTE) begin
                        s = push_f(s, joiner);
                    end else if (is_space(s.st.prev_char) && mode_i) begin
                        s = replace_f(s, CH_AMP);
                        s.st.prev_char = CH_AMP;
                    end
                end
                if (is_space(s.st.prev_char)) begin
                    if (sym) begin
                        s = replace_f(s, c);
                    end else begin
                        if (!s.st.in_phrase && mode_i) begin
                            s = replace_f(s, CH_AMP);
                        end
                        s = push_f(s, c);
                    end
                    s.st.prev_char = c;
                end else if (!(is_mark(s.st.prev_char, mode_i) && ws)) begin
                    if (!s.st.in_phrase && s.st.prev_char == CH_QUOTE && alpha) begin
                        s = push_f(s, joiner);
                    end
                    s = push_f(s, c);
                    s.st.prev_char = c;
                end
            end
        end

        // end-of-query word
        fin = '{invalid: 1'b0, last: 1'b1, valid_char: 1'b0, ch: CH_NUL};
        if (s.st.aborted) begin
            fin.invalid = 1'b1;
        end else if (!s.st.held_valid) begin
            fin.invalid = 1'b0;
        end else if (is_space(s.st.held_char)) begin
            fin.invalid = s.st.any_committed && s.st.before_held == CH_DOLLAR;
        end else if (s.st.held_char == CH_DOLLAR) begin
            fin.invalid = 1'b1;
        end else begin
            fin.valid_char = 1'b1;
            fin.ch = s.st.held_char;
        end

        ent_o[0] = (s.n != 2'd0) ?
            qtn_res_t'{invalid: 1'b0, last: 1'b0, valid_char: 1'b1, ch: s.ech[0]} : fin;
        ent_o[1] = (s.n == 2'd2) ?
            qtn_res_t'{invalid: 1'b0, last: 1'b0, valid_char: 1'b1, ch: s.ech[1]} : fin;
        ent_o[2] = fin;
        cnt_o    = s.n + {1'b0, last_i};
        st_o     = last_i ? STATE_CLEAR : s.st;
    end

endmodule

// ===== sv/qtn_obuf.sv =====
// qtn_obuf: three-word result buffer; drains one word per cycle while
// m_tready is high. Takes a byte's words at once. Depends on qtn_pkg.
module qtn_obuf (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load_i,
    input  qtn_pkg::qtn_res_t [2:0]  ent_i,
    input  logic [1:0]               cnt_i,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output qtn_pkg::qtn_res_t        head_o,
    output qtn_pkg::qtn_obuf_stat_t  stat_o
);
    import qtn_pkg::*;

    qtn_res_t   ent_reg [3];
    qtn_res_t   ent_next [3];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    always_comb begin
        pop         = (cnt_reg != 2'd0) && m_tready;
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        ent_next[2] = ent_reg[2];
        cnt_next    = cnt_reg;
        if (load_i) begin
            ent_next[0] = ent_i[0];
            ent_next[1] = ent_i[1];
            ent_next[2] = ent_i[2];
            cnt_next    = cnt_i;
        end else if (pop) begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
        stat_o.room = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
        stat_o.busy = cnt_reg != 2'd0;
        m_tvalid    = stat_o.busy;
        head_o      = ent_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
        ent_reg[2] <= ent_next[2];
    end

endmodule

// ===== sv/query_text_normalizer.sv =====
// query_text_normalizer: top level; input register, parser state, mode register.
// Instantiates qtn_step and qtn_obuf; depends on qtn_pkg.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_tvalid/tready  | tdata = in_char, tlast = in_last
//  m_      | out       | m_tvalid/tready  | tdata = out_char, tlast = out_last,
//          |           |                  | tuser = out_valid_char, out_invalid
//  cfg_    | in        | cfg_wr_en        | cfg_wr_data = infix_mode
//
// A byte is taken into the input register, processed combinationally, and its
// 0 to 3 result words leave a three-word buffer one per cycle while m_tready
// is high. A byte with at most one result word sustains one byte per cycle
// while m_tready is high; a byte with more words holds the input stage until
// its last word leaves the buffer. Reset is synchronous; no clearing pass.
// m_tready low stalls the buffer, then the input register, then s_tready.
module query_text_normalizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,
    output logic [1:0] m_tuser,   // [0] out_valid_char, [1] out_invalid
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);
    import qtn_pkg::*;

    logic           in_vld_reg;
    logic           in_vld_next;
    logic [7:0]     in_char_reg;
    logic           in_last_reg;
    logic           mode_reg;
    qtn_state_t     st_reg;
    qtn_state_t     st_next;
    qtn_res_t [2:0] ent;
    logic [1:0]     cnt;
    qtn_res_t       head;
    qtn_obuf_stat_t ostat;
    logic           adv;
    logic           s_acc;

    qtn_step u_step (
        .st_i   (st_reg),
        .ch_i   (in_char_reg),
        .last_i (in_last_reg),
        .mode_i (mode_reg),
        .st_o   (st_next),
        .ent_o  (ent),
        .cnt_o  (cnt)
    );

    qtn_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (adv),
        .ent_i    (ent),
        .cnt_i    (cnt),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .head_o   (head),
        .stat_o   (ostat)
    );

    always_comb begin
        adv         = in_vld_reg && ostat.room;
        s_tready    = !in_vld_reg || adv;
        s_acc       = s_tvalid && s_tready;
        in_vld_next = s_acc ? 1'b1 : (adv ? 1'b0 : in_vld_reg);
        m_tdata     = head.ch;
        m_tlast     = head.last;
        m_tuser     = {head.invalid, head.valid_char};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            mode_reg   <= 1'b1;
            st_reg     <= STATE_CLEAR;
        end else begin
            in_vld_reg <= in_vld_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (adv) begin
                st_reg <= st_next;
            end
        end
        if (s_acc) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

// ===== sv/qtn_checker.sv =====
// qtn_checker: port-level checks of the query text normalizer result channel.
// Bound to query_text_normalizer; sees its ports only.
module qtn_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("end marker not final or not zero");

    a_invalid_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("invalid flag on a non-final or data word");

endmodule

bind query_text_normalizer qtn_checker u_qtn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
